FILE: hw/rtl/ist_pkg.sv
// shared types and codes for the interpolation search table unit
// no dependencies
package ist_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FOUND    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RLO,
        S_RHI,
        S_CHK,
        S_MUL0,
        S_MUL1,
        S_DIV,
        S_RP,
        S_CMP
    } t_state;

    localparam int KEY_W = 64;
    localparam int POS_W = 10;

endpackage

FILE: hw/rtl/interpolation_search_table_unit.sv
// interpolation search over an ascending table of 64-bit keys
// depends on ist_pkg; key table is a one-port-write, one-port-read memory
//
//  channel  | ports                       | handshake
//  command  | i_func, i_key               | accepted when start && !busy
//  result   | o_status, o_position        | o_valid high for one cycle, no stall
//
// clear, append and unused func: result in the cycle after the command.
// search: each probe reads and checks the window ends (S_RLO, S_RHI, S_CHK), multiplies
// in two halves (S_MUL0, S_MUL1), divides bit by bit in S_DIV and then reads and
// compares the probe (S_RP, S_CMP). the divider is a restoring divider.
// reset empties the table at once; no clearing pass. results cannot be stalled.
module interpolation_search_table_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [63:0]           i_key,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [9:0]            o_position
);
    import ist_pkg::*;

    localparam int IW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = IW + 1;
    localparam int PW = IW + KEY_W;
    localparam int DCW = $clog2(IW + 1);

    logic [KEY_W-1:0] key_store [TABLE_DEPTH];

    t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_low, n_low;
    logic [IW-1:0]    r_high, n_high;
    logic [IW-1:0]    r_p, n_p;
    logic [IW-1:0]    r_span, n_span;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_klo, n_klo;
    logic [KEY_W-1:0] r_num, n_num;
    logic [KEY_W-1:0] r_den, n_den;
    logic [PW-1:0]    r_prod, n_prod;
    logic [KEY_W-1:0] r_rem, n_rem;
    logic [IW-1:0]    r_dlo, n_dlo;
    logic [IW-1:0]    r_quo, n_quo;
    logic [DCW-1:0]   r_dcnt, n_dcnt;
    logic             r_valid, n_valid;
    logic [1:0]       r_status, n_status;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [KEY_W-1:0] r_rdata;

    logic [IW-1:0]    w_raddr;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    logic [IW+31:0]   w_pp;
    logic [31:0]      w_mb;
    logic [PW-1:0]    w_full;
    logic [KEY_W:0]   w_trial;
    logic [KEY_W:0]   w_diff;
    logic [IW+9:0]    w_posx;
    logic [IW-1:0]    w_posidx;

    assign w_mb   = (r_state == S_MUL0) ? r_num[31:0] : r_num[63:32];
    assign w_pp   = (IW+32)'(r_span) * (IW+32)'(w_mb);
    assign w_full = r_prod + {w_pp, 32'b0};
    assign w_trial = {r_rem, r_dlo[IW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_posx  = {10'b0, w_posidx};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            key_store[w_waddr] <= i_key;
        end
        r_rdata <= key_store[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_low    <= n_low;
        r_high   <= n_high;
        r_p      <= n_p;
        r_span   <= n_span;
        r_key    <= n_key;
        r_klo    <= n_klo;
        r_num    <= n_num;
        r_den    <= n_den;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_dlo    <= n_dlo;
        r_quo    <= n_quo;
        r_dcnt   <= n_dcnt;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_low    = r_low;
        n_high   = r_high;
        n_p      = r_p;
        n_span   = r_span;
        n_key    = r_key;
        n_klo    = r_klo;
        n_num    = r_num;
        n_den    = r_den;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_dlo    = r_dlo;
        n_quo    = r_quo;
        n_dcnt   = r_dcnt;
        n_valid  = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;
        w_raddr  = r_low[IW-1:0];
        w_we     = 1'b0;
        w_waddr  = r_count[IW-1:0];
        w_posidx = r_p;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = i_key;
                    case (t_func'(i_func))
                        FUNC_CLEAR: begin
                            n_count  = '0;
                            n_valid  = 1'b1;
                            n_status = ST_DONE;
                            n_pos    = '0;
                        end
                        FUNC_APPEND: begin
                            n_valid = 1'b1;
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_pos    = '0;
                            end else begin
                                w_we     = 1'b1;
                                w_posidx = r_count[IW-1:0];
                                n_status = ST_DONE;
                                n_pos    = w_posx[9:0];
                                n_count  = r_count + 1'b1;
                            end
                        end
                        FUNC_SEARCH: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_NOTFOUND;
                                n_pos    = '0;
                            end else begin
                                n_low   = '0;
                                n_high  = IW'(r_count - 1'b1);
                                n_state = S_RLO;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_DONE;
                            n_pos    = '0;
                        end
                    endcase
                end
            end
            S_RLO: begin
                w_raddr = r_low[IW-1:0];
                n_state = S_RHI;
            end
            S_RHI: begin
                w_raddr = r_high;
                n_klo   = r_rdata;
                n_state = S_CHK;
            end
            S_CHK: begin
                w_posidx = r_low[IW-1:0];
                if (r_key < r_klo || r_key > r_rdata) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_pos    = '0;
                    n_state  = S_IDLE;
                end else if (r_klo == r_rdata) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_klo == r_key) begin
                        n_status = ST_FOUND;
                        n_pos    = w_posx[9:0];
                    end else begin
                        n_status = ST_NOTFOUND;
                        n_pos    = '0;
                    end
                end else begin
                    n_span  = r_high - r_low[IW-1:0];
                    n_num   = r_key - r_klo;
                    n_den   = r_rdata - r_klo;
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                n_prod  = PW'(w_pp);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_rem   = w_full[PW-1:IW];
                n_dlo   = w_full[IW-1:0];
                n_quo   = '0;
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_dlo = r_dlo << 1;
                if (w_trial >= {1'b0, r_den}) begin
                    n_rem = w_diff[KEY_W-1:0];
                    n_quo = IW'({r_quo, 1'b1});
                end else begin
                    n_rem = w_trial[KEY_W-1:0];
                    n_quo = IW'({r_quo, 1'b0});
                end
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DCW'(IW - 1)) begin
                    if (n_quo > r_span) begin
                        n_quo = r_span;
                    end
                    n_p     = r_low[IW-1:0] + n_quo;
                    n_state = S_RP;
                end
            end
            S_RP: begin
                w_raddr = r_p;
                n_state = S_CMP;
            end
            S_CMP: begin
                w_posidx = r_p;
                if (r_rdata == r_key) begin
                    n_valid  = 1'b1;
                    n_status = ST_FOUND;
                    n_pos    = w_posx[9:0];
                    n_state  = S_IDLE;
                end else if (r_rdata < r_key) begin
                    n_low = {1'b0, r_p} + 1'b1;
                    if (n_low > {1'b0, r_high}) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOTFOUND;
                        n_pos    = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_RLO;
                    end
                end else if (r_p == '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_pos    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_high = r_p - 1'b1;
                    if (r_low > {1'b0, n_high}) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOTFOUND;
                        n_pos    = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_RLO;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_position = r_pos;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while search still running");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_valid || busy))
        else $error("accepted word produced neither result nor search");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule

FILE: sim/ist_checker.sv
// result checker for the interpolation search table unit: keeps its own key table,
// predicts status and position of every accepted command word and compares results
// depends on ist_pkg
module ist_checker
    import ist_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_key,
    input  logic        o_valid,
    input  logic [1:0]  o_status,
    input  logic [9:0]  o_position,
    output int          o_errors,
    output int          o_pending,
    output int          o_found
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;

    typedef struct packed {
        t_status    status;
        logic [9:0] position;
    } t_answer;

    logic [63:0] key_table [DEPTH];
    int          key_count;
    t_answer     answers_due [$];

    function automatic void lookup(input logic [63:0] k, output t_status st,
                                   output logic [9:0] pos);
        int           lo;
        int           hi;
        int           p;
        logic [63:0]  klo;
        logic [63:0]  khi;
        logic [127:0] off;
        st  = ST_NOTFOUND;
        pos = '0;
        if (key_count == 0) return;
        lo = 0;
        hi = key_count - 1;
        while (lo <= hi) begin
            klo = key_table[lo];
            khi = key_table[hi];
            if (k < klo || k > khi) return;
            if (klo == khi) begin
                if (klo == k) begin
                    st  = ST_FOUND;
                    pos = lo[9:0];
                end
                return;
            end
            off = (128'(hi - lo) * 128'(k - klo)) / 128'(khi - klo);
            if (off > 128'(hi - lo)) off = 128'(hi - lo);
            p = lo + int'(off);
            if (key_table[p] == k) begin
                st  = ST_FOUND;
                pos = p[9:0];
                return;
            end
            if (key_table[p] < k) begin
                lo = p + 1;
            end else begin
                if (p == 0) return;
                hi = p - 1;
            end
        end
    endfunction

    function automatic t_answer predict(input t_func f, input logic [63:0] k);
        t_answer a;
        a.status   = ST_DONE;
        a.position = '0;
        case (f)
            FUNC_CLEAR: begin
                key_count = 0;
            end
            FUNC_APPEND: begin
                if (key_count >= DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    key_table[key_count] = k;
                    a.position = key_count[9:0];
                    key_count++;
                end
            end
            FUNC_SEARCH: begin
                lookup(k, a.status, a.position);
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            key_count = 0;
            o_errors  = 0;
            o_found   = 0;
            answers_due.delete();
        end else begin
            if (o_valid) begin
                if (answers_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result status=%0d position=%0d",
                                 $time, o_status, o_position);
                end else begin
                    want = answers_due.pop_front();
                    if (want.status == ST_FOUND) o_found++;
                    if (o_status !== want.status || o_position !== want.position) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mismatch status exp=%0d act=%0d position exp=%0d act=%0d",
                                     $time, want.status, o_status, want.position, o_position);
                    end
                end
            end
            if (start && !busy)
                answers_due.push_back(predict(t_func'(i_func), i_key));
        end
        o_pending <= answers_due.size();
    end
endmodule

FILE: sim/tb_top.sv
// top testbench for the interpolation search table unit: drives command words,
// watches progress and reports the verdict; checking is done in ist_checker
// depends on ist_pkg, ist_checker and interpolation_search_table_unit
module tb_top;
    import ist_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int ITEM_TARGET    = 1450;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [63:0] i_key;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [9:0]  o_position;
    int          errors;
    int          pending;
    int          found;
    int          items_sent;
    int          searches_sent;
    int          quiet_cycles;
    bit          no_gaps;
    logic [63:0] appended [$];

    interpolation_search_table_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_key(i_key), .o_valid(o_valid),
        .o_status(o_status), .o_position(o_position)
    );

    ist_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_key(i_key), .o_valid(o_valid),
        .o_status(o_status), .o_position(o_position),
        .o_errors(errors), .o_pending(pending), .o_found(found)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send(input t_func f, input logic [63:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_func <= f;
        i_key  <= k;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (f == FUNC_SEARCH) searches_sent++;
        if (f == FUNC_CLEAR) appended.delete();
        if (f == FUNC_APPEND && appended.size() < 1024) appended.push_back(k);
    endtask

    task automatic fill_sorted(input int n, input bit sorted);
        logic [63:0] k;
        logic [64:0] nxt;
        int          sh;
        k = sorted ? (rand_key() >> $urandom_range(0, 63)) : rand_key();
        for (int i = 0; i < n; i++) begin
            send(FUNC_APPEND, k);
            if (sorted) begin
                sh  = $urandom_range(0, 63);
                nxt = 65'(k) + 65'(($urandom_range(0, 3) == 0) ? 64'd0 : (rand_key() >> sh));
                k   = nxt[64] ? 64'hFFFF_FFFF_FFFF_FFFF : nxt[63:0];
            end else begin
                k = rand_key();
            end
        end
    endtask

    task automatic probe_table(input int n);
        logic [63:0] k;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (appended.size() == 0 || r > 7) begin
                k = rand_key();
            end else begin
                k = appended[$urandom_range(0, appended.size() - 1)];
                if (r == 6) k = k + 64'd1;
                if (r == 7) k = k - 64'd1;
            end
            send(FUNC_SEARCH, k);
        end
    endtask

    initial begin
        int    kind;
        bit    did_full;
        start         <= 1'b0;
        i_func        <= FUNC_CLEAR;
        i_key         <= '0;
        i_rst_n       <= 1'b0;
        items_sent    = 0;
        searches_sent = 0;
        no_gaps       = 1'b0;
        did_full      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, equal ends, unused func
        send(FUNC_SEARCH, 64'd0);
        send(FUNC_APPEND, 64'd0);
        send(FUNC_SEARCH, 64'd0);
        send(FUNC_APPEND, 64'd100);
        send(FUNC_APPEND, 64'd1000);
        send(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FFFF);
        send(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
        send(FUNC_SEARCH, 64'd100);
        send(FUNC_SEARCH, 64'd101);
        send(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE);
        send(FUNC_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send(FUNC_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send(FUNC_SEARCH, 64'd100);
        send(FUNC_APPEND, 64'd5);
        send(FUNC_APPEND, 64'd5);
        send(FUNC_APPEND, 64'd5);
        send(FUNC_SEARCH, 64'd5);
        send(FUNC_SEARCH, 64'd4);
        send(FUNC_SEARCH, 64'd6);
        send(FUNC_APPEND, 64'd3);
        send(FUNC_SEARCH, 64'd3);
        send(FUNC_SEARCH, 64'd5);
        send(FUNC_CLEAR, 64'd0);

        while (items_sent < ITEM_TARGET) begin
            kind    = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (!did_full && items_sent > ITEM_TARGET / 3) begin
                did_full = 1'b1;
                send(FUNC_CLEAR, rand_key());
                fill_sorted(1030, 1'b1);
                probe_table(20);
            end else if (kind < 70) begin
                send(FUNC_CLEAR, rand_key());
                fill_sorted($urandom_range(1, 40), 1'b1);
                probe_table($urandom_range(3, 25));
            end else if (kind < 82) begin
                send(FUNC_CLEAR, rand_key());
                fill_sorted($urandom_range(1, 20), 1'b0);
                probe_table($urandom_range(3, 15));
            end else begin
                repeat ($urandom_range(1, 8))
                    send(t_func'($urandom_range(0, 3)), rand_key());
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("%0d command words sent, %0d searches, %0d found in the table",
                 items_sent, searches_sent, found);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
